>>> hw/rtl/mandelbrot_escape_color_core_macros.svh
// Assertion macros used by the checker file of the escape-time color core.
`ifndef MANDELBROT_ESCAPE_COLOR_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_COLOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mec_pkg.sv
// Package with types, constants and helpers of the escape-time color core.
`default_nettype none

package mec_pkg;

  localparam int unsigned MAX_ITER_DEF  = 64;
  localparam int unsigned HALF_SPAN_DEF = 400;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PIX_W      = 10;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned ITER_W     = 7;
  localparam int unsigned STEP_W     = 31;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = 2'd2;

  localparam logic [STEP_W-1:0] PIXEL_STEP_RST = 31'd41943;

  // Full scale of the scaled count; also the modulus of the green channel.
  localparam int unsigned COLOR_MAX = 255;

  // Escape bound |z|^2 > 16 in Q16.48.
  localparam logic [63:0] MAG_LIMIT = 64'h0010_0000_0000_0000;

  localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_SQ,
    ST_UPD,
    ST_DONE
  } mec_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > SAT_HI) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      res = -32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mec_if.sv
// Handshake channel interfaces of the escape-time color core.
`default_nettype none

interface mec_in_if;
  import mec_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mec_out_if;
  import mec_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [ITER_W-1:0]  iterations;

  modport source (output valid, output red, output green, output blue,
                  output iterations, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input iterations, output ready);
endinterface

interface mec_cfg_if;
  import mec_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mandelbrot_escape_color_core.sv
// Channel   | Dir | Word
// ----------+-----+----------------------------------------------
// in_ch     | in  | pixel_x[9:0], pixel_y[9:0]
// out_ch    | out | red[7:0], green[7:0], blue[7:0], iterations[6:0]
// cfg_ch    | in  | index[1:0] (center_x, center_y, pixel_step), data[31:0]
//
// A pixel passes ST_MAP_MUL and ST_MAP_ADD, then loops over ST_SQ and ST_UPD until
// the point escapes or the count reaches MAX_ITER, and ends in ST_DONE. The loop
// runs on the shared complex-square unit: ST_SQ forms zr*zr, zi*zi and zr*zi,
// and ST_UPD tests and updates z.
// in_ch.ready is high only while idle; a finished word waits in the output
// register, and the core takes the next pixel meanwhile. cfg_ch is always ready.
// rst_n is synchronous and restores center 0 and pixel_step 41943.
`default_nettype none

module mandelbrot_escape_color_core
  import mec_pkg::*;
#(
  parameter int unsigned MAX_ITER  = MAX_ITER_DEF,
  parameter int unsigned HALF_SPAN = HALF_SPAN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mec_in_if.sink     in_ch,
  mec_out_if.source  out_ch,
  mec_cfg_if.sink    cfg_ch
);

  localparam int unsigned CNT_W  = $clog2(MAX_ITER + 1);
  localparam int unsigned ACC_W  = CNT_W + 1;
  localparam int unsigned S_QUO  = COLOR_MAX / MAX_ITER;
  localparam int unsigned S_REM  = COLOR_MAX % MAX_ITER;
  localparam int unsigned OFS_W  = 13;

  mec_state_t state_r, state_nxt;

  logic signed [31:0]      center_x_r, center_y_r;
  logic [STEP_W-1:0]       step_r;
  logic signed [OFS_W-1:0] px_r, py_r;
  logic signed [31:0]      cr_r, ci_r, zr_r, zi_r;
  logic signed [63:0]      p0_r, p1_r, p2_r;
  logic [CNT_W-1:0]        k_r, j_fin_r;
  logic [ACC_W-1:0]        acc_r;
  logic [COLOR_W-1:0]      s_r, s_prev_r, s_fin_r;

  logic                    out_valid_r;
  logic [COLOR_W-1:0]      red_r, green_r, blue_r;
  logic [ITER_W-1:0]       iter_r;

  logic in_fire, out_free, mul_en;
  logic signed [31:0] a0, b0, a1, b1, a2, b2;
  logic signed [63:0] m0, m1, m2;
  logic [63:0]        mag;
  logic               escaped, at_limit;
  logic signed [63:0] nr_full, ni_full;
  logic [ACC_W-1:0]   acc_sum, acc_nxt;
  logic               acc_wrap;
  logic [COLOR_W-1:0] s_nxt;

  assign in_fire    = in_ch.valid & in_ch.ready;
  assign out_free   = ~out_valid_r | out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_MAP_MUL;
      ST_MAP_MUL: state_nxt = ST_MAP_ADD;
      ST_MAP_ADD: state_nxt = ST_SQ;
      ST_SQ:      state_nxt = ST_UPD;
      ST_UPD:     if (escaped || at_limit) state_nxt = ST_DONE;
                  else state_nxt = ST_SQ;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Operand selection of the shared multiplier unit.
  always_comb begin
    a0 = zr_r;
    b0 = zr_r;
    a1 = zi_r;
    b1 = zi_r;
    a2 = zr_r;
    b2 = zi_r;
    mul_en = 1'b0;
    unique case (state_r)
      ST_MAP_MUL: begin
        a0 = 32'(px_r);
        b0 = signed'({1'b0, step_r});
        a1 = 32'(py_r);
        b1 = signed'({1'b0, step_r});
        mul_en = 1'b1;
      end
      ST_SQ: begin
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign m0 = a0 * b0;
  assign m1 = a1 * b1;
  assign m2 = a2 * b2;

  // Squares are never negative, so their unsigned sum cannot wrap.
  assign mag      = 64'(p0_r) + 64'(p1_r);
  assign escaped  = (mag > MAG_LIMIT);
  assign at_limit = (k_r == CNT_W'(MAX_ITER));

  assign nr_full = ((p0_r - p1_r) >>> 24) + 64'(cr_r);
  assign ni_full = (p2_r >>> 23) + 64'(ci_r);

  // Running quotient of k*255/MAX_ITER, carried along with the count.
  assign acc_sum  = acc_r + ACC_W'(S_REM);
  assign acc_wrap = (acc_sum >= ACC_W'(MAX_ITER));
  assign acc_nxt  = acc_wrap ? acc_sum - ACC_W'(MAX_ITER) : acc_sum;
  assign s_nxt    = s_r + COLOR_W'(S_QUO) + COLOR_W'(acc_wrap);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      center_x_r  <= '0;
      center_y_r  <= '0;
      step_r      <= PIXEL_STEP_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_CENTER_X:   center_x_r <= signed'(cfg_ch.data);
          CFG_CENTER_Y:   center_y_r <= signed'(cfg_ch.data);
          CFG_PIXEL_STEP: step_r     <= cfg_ch.data[STEP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_r <= signed'({3'b000, in_ch.pixel_x}) - OFS_W'(HALF_SPAN);
      py_r <= signed'({3'b000, in_ch.pixel_y}) - OFS_W'(HALF_SPAN);
    end
    if (mul_en) begin
      p0_r <= m0;
      p1_r <= m1;
      p2_r <= m2;
    end
    if (state_r == ST_MAP_ADD) begin
      cr_r     <= sat32(64'(center_x_r) + p0_r);
      ci_r     <= sat32(64'(center_y_r) + p1_r);
      zr_r     <= '0;
      zi_r     <= '0;
      k_r      <= '0;
      acc_r    <= '0;
      s_r      <= '0;
      s_prev_r <= '0;
    end
    if (state_r == ST_UPD) begin
      // The products on hand belong to z after k updates; z0 = 0 never escapes.
      if (escaped) begin
        j_fin_r <= k_r - CNT_W'(1);
        s_fin_r <= s_prev_r;
      end else if (at_limit) begin
        j_fin_r <= k_r;
        s_fin_r <= s_r;
      end else begin
        zr_r     <= sat32(nr_full);
        zi_r     <= sat32(ni_full);
        k_r      <= k_r + CNT_W'(1);
        acc_r    <= acc_nxt;
        s_prev_r <= s_r;
        s_r      <= s_nxt;
      end
    end
    if (state_r == ST_DONE && out_free) begin
      red_r   <= {s_fin_r[5:0], 2'b00};
      green_r <= (s_fin_r == COLOR_W'(COLOR_MAX)) ? '0 : s_fin_r;
      blue_r  <= {s_fin_r[4:0], 3'b000};
      iter_r  <= ITER_W'(j_fin_r);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red        = red_r;
  assign out_ch.green      = green_r;
  assign out_ch.blue       = blue_r;
  assign out_ch.iterations = iter_r;

endmodule

`default_nettype wire

>>> hw/rtl/mec_checker.sv
// Port-level checker of the escape-time color core and its bind statement.
`default_nettype none
`include "mandelbrot_escape_color_core_macros.svh"

module mec_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       cfg_ready,
  input logic [7:0] red,
  input logic [7:0] blue
);

  logic color_ok;

  // Red and blue both come from the low bits of the scaled count, so their
  // shared bits must agree and their padding bits must be zero.
  assign color_ok = (red[1:0] == 2'b00) && (blue[2:0] == 3'b000) &&
                    (red[6:2] == blue[7:3]);

  `MEC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped")
  `MEC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready while busy")
  `MEC_ASSERT_IMP(a_color_link, out_valid, color_ok, "red and blue disagree")
  `MEC_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready, "configuration port stalled")

endmodule

bind mandelbrot_escape_color_core mec_checker u_mec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_ready (cfg_ch.ready),
  .red       (out_ch.red),
  .blue      (out_ch.blue)
);

`default_nettype wire
